FILE: src/fkhash_pkg.sv
// Shared types, constants and helper functions for the fraction-key hash table.
// No dependencies; compiled first.
package fkhash_pkg;

   localparam int TABLE_SIZE_DEF    = 16;
   localparam int PRIME_MODULUS_DEF = 13;
   localparam int SLOT_W_DEF        = $clog2(TABLE_SIZE_DEF);

   localparam int NUM_W = 16;
   localparam int KEY_W = 2 * NUM_W;
   localparam int MAG_W = NUM_W + 1;
   localparam int BASE_W = 20;
   localparam int DIGIT_W = 4;
   localparam int DIGITS = BASE_W / DIGIT_W;
   localparam int DIGIT_CNT_W = $clog2(DIGITS + 1);

   localparam int HASH_MUL_NUM = 7;
   localparam int HASH_MUL_DEN = 11;
   localparam int PROBE_STEP   = 11;

   localparam int STATUS_W = 3;
   typedef logic [STATUS_W-1:0] status_type;

   localparam status_type ST_INSERTED  = 3'd0;
   localparam status_type ST_FOUND     = 3'd1;
   localparam status_type ST_DUPLICATE = 3'd2;
   localparam status_type ST_NOT_FOUND = 3'd3;
   localparam status_type ST_FULL      = 3'd4;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_LOOKUP = 1'b1;

   typedef struct packed {
      logic             used;
      logic [KEY_W-1:0] key;
   } entry_type;

   typedef struct packed {
      logic start;
   } mod_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mod_sts_type;

   function automatic logic [MAG_W-1:0] magnitude(input logic [NUM_W-1:0] v);
      logic [MAG_W-1:0] ext;
      ext = {v[NUM_W-1], v};
      return v[NUM_W-1] ? (~ext + MAG_W'(1)) : ext;
   endfunction

   function automatic logic [BASE_W-1:0] hash_base(input logic [NUM_W-1:0] num,
                                                   input logic [NUM_W-1:0] den);
      logic [BASE_W-1:0] mn;
      logic [BASE_W-1:0] md;
      mn = BASE_W'(magnitude(num));
      md = BASE_W'(magnitude(den));
      return mn * BASE_W'(HASH_MUL_NUM) + md * BASE_W'(HASH_MUL_DEN);
   endfunction

endpackage

FILE: src/fkhash_ifs.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on fkhash_pkg.
interface fkhash_req_if;
   import fkhash_pkg::*;
   logic             valid;
   logic             ready;
   logic             mode;
   logic [NUM_W-1:0] numerator;
   logic [NUM_W-1:0] denominator;

   modport source (output valid, mode, numerator, denominator, input ready);
   modport sink   (input valid, mode, numerator, denominator, output ready);
endinterface

interface fkhash_rsp_if #(parameter int SLOT_W = fkhash_pkg::SLOT_W_DEF);
   import fkhash_pkg::*;
   logic              valid;
   logic              ready;
   status_type        status;
   logic [SLOT_W-1:0] slot;

   modport source (output valid, status, slot, input ready);
   modport sink   (input valid, status, slot, output ready);
endinterface

FILE: src/fkhash_mod.sv
// Shared modulo reducer: restoring remainder, four dividend bits per cycle.
// Depends on fkhash_pkg.
module fkhash_mod #(
   parameter int MOD_W = 5
) (
   input  logic                       clock,
   input  logic                       reset,
   input  fkhash_pkg::mod_ctl_type    ctl,
   input  logic [fkhash_pkg::BASE_W-1:0] dividend,
   input  logic [MOD_W-1:0]           modulus,
   output fkhash_pkg::mod_sts_type    sts,
   output logic [MOD_W-1:0]           remainder
);
   import fkhash_pkg::*;

   logic [BASE_W-1:0]      div_ff, div_in;
   logic [MOD_W-1:0]       rem_ff, rem_in;
   logic [MOD_W-1:0]       mod_ff, mod_in;
   logic [DIGIT_CNT_W-1:0] cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [MOD_W-1:0]       step_rem;

   always_comb begin
      logic [MOD_W:0] t;
      logic [MOD_W-1:0] r;
      r = rem_ff;
      for (int k = 0; k < DIGIT_W; k++) begin
         t = {r, div_ff[BASE_W-1-k]};
         if (t >= {1'b0, mod_ff}) begin
            t = t - {1'b0, mod_ff};
         end
         r = t[MOD_W-1:0];
      end
      step_rem = r;
   end

   always_comb begin
      div_in  = div_ff;
      rem_in  = rem_ff;
      mod_in  = mod_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         div_in  = dividend;
         rem_in  = '0;
         mod_in  = modulus;
         cnt_in  = DIGIT_CNT_W'(DIGITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = step_rem;
         div_in = div_ff << DIGIT_W;
         cnt_in = cnt_ff - DIGIT_CNT_W'(1);
         if (cnt_ff == DIGIT_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      div_ff <= div_in;
      rem_ff <= rem_in;
      mod_ff <= mod_in;
   end

   assign sts.busy  = busy_ff;
   assign sts.done  = done_ff;
   assign remainder = rem_ff;

endmodule

FILE: src/fkhash_mem.sv
// Slot store: one write port, one registered read port.
// Depends on fkhash_pkg for the entry layout.
module fkhash_mem #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  fkhash_pkg::entry_type wr_data,
   input  logic [ADDR_W-1:0]     rd_addr,
   output fkhash_pkg::entry_type rd_data
);
   import fkhash_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/fraction_key_open_address_hash_table_core.sv
// Top level: probe sequencer of the fraction-key open-addressing hash table.
// Depends on fkhash_pkg, fkhash_ifs, fkhash_mod and fkhash_mem.
//
//   channel | dir | fields                         | transfer when
//   req     | in  | mode, numerator, denominator   | req.valid && req.ready
//   rsp     | out | status, slot                   | rsp.valid && rsp.ready
//
// rsp.valid rises after the req transfer and k probes (1..TABLE_SIZE): the shared modulo
// unit reduces the hash base modulo PRIME_MODULUS, each probe reads the registered slot
// store (S_READ) and checks the entry (S_CHECK), and S_DONE loads the result register.
// With PRIME_MODULUS > TABLE_SIZE the same unit folds each probe address modulo TABLE_SIZE.
// After reset the block clears all TABLE_SIZE slots with req.ready low. req.ready is
// high only when idle; a held result stalls only the next load in S_DONE.
module fraction_key_open_address_hash_table_core #(
   parameter int TABLE_SIZE    = fkhash_pkg::TABLE_SIZE_DEF,
   parameter int PRIME_MODULUS = fkhash_pkg::PRIME_MODULUS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   fkhash_req_if.sink          req,
   fkhash_rsp_if.source        rsp
);
   import fkhash_pkg::*;

   localparam int  ADDR_W  = $clog2(TABLE_SIZE);
   localparam int  H_W     = $clog2(PRIME_MODULUS);
   localparam int  MAXMOD  = (PRIME_MODULUS > TABLE_SIZE) ? PRIME_MODULUS : TABLE_SIZE;
   localparam int  MOD_W   = $clog2(MAXMOD + 1);
   localparam int  STEP    = PROBE_STEP % PRIME_MODULUS;
   localparam bit  FOLD    = (PRIME_MODULUS > TABLE_SIZE);

   localparam logic [2:0] S_CLEAR   = 3'd0;
   localparam logic [2:0] S_IDLE    = 3'd1;
   localparam logic [2:0] S_HASH    = 3'd2;
   localparam logic [2:0] S_FOLD_GO = 3'd3;
   localparam logic [2:0] S_FOLD    = 3'd4;
   localparam logic [2:0] S_READ    = 3'd5;
   localparam logic [2:0] S_CHECK   = 3'd6;
   localparam logic [2:0] S_DONE    = 3'd7;

   logic [2:0]        state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic              mode_ff, mode_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [H_W-1:0]    h_ff, h_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [ADDR_W-1:0] probe_ff, probe_in;
   status_type        res_status_ff, res_status_in;
   logic [ADDR_W-1:0] res_slot_ff, res_slot_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0] rsp_slot_ff, rsp_slot_in;

   mod_ctl_type       mod_ctl;
   mod_sts_type       mod_sts;
   logic [BASE_W-1:0] mod_dividend;
   logic [MOD_W-1:0]  mod_modulus;
   logic [MOD_W-1:0]  mod_rem;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   entry_type         wr_data;
   entry_type         rd_data;

   logic [H_W:0]      h_sum;
   logic [H_W-1:0]    h_next;
   logic              req_xfer;

   fkhash_mod #(.MOD_W(MOD_W)) u_mod (
      .clock     (clock),
      .reset     (reset),
      .ctl       (mod_ctl),
      .dividend  (mod_dividend),
      .modulus   (mod_modulus),
      .sts       (mod_sts),
      .remainder (mod_rem)
   );

   fkhash_mem #(.DEPTH(TABLE_SIZE), .ADDR_W(ADDR_W)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   assign req.ready  = (state_ff == S_IDLE);
   assign req_xfer   = req.valid && (state_ff == S_IDLE);
   assign rsp.valid  = rsp_valid_ff;
   assign rsp.status = rsp_status_ff;
   assign rsp.slot   = rsp_slot_ff;

   always_comb begin
      h_sum = {1'b0, h_ff} + (H_W + 1)'(STEP);
      if (h_sum >= (H_W + 1)'(PRIME_MODULUS)) begin
         h_sum = h_sum - (H_W + 1)'(PRIME_MODULUS);
      end
      h_next = h_sum[H_W-1:0];
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      mode_in       = mode_ff;
      key_in        = key_ff;
      h_in          = h_ff;
      addr_in       = addr_ff;
      probe_in      = probe_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      mod_ctl.start = 1'b0;
      mod_dividend  = hash_base(req.numerator, req.denominator);
      mod_modulus   = MOD_W'(PRIME_MODULUS);
      wr_en         = 1'b0;
      wr_addr       = addr_ff;
      wr_data       = '{used: 1'b1, key: key_ff};

      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '{used: 1'b0, key: '0};
            clr_in  = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(TABLE_SIZE - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_xfer) begin
               mode_in       = req.mode;
               key_in        = {req.numerator, req.denominator};
               mod_ctl.start = 1'b1;
               state_in      = S_HASH;
            end
         end
         S_HASH: begin
            if (mod_sts.done) begin
               h_in     = H_W'(mod_rem);
               addr_in  = ADDR_W'(mod_rem);
               probe_in = '0;
               state_in = FOLD ? S_FOLD_GO : S_READ;
            end
         end
         S_FOLD_GO: begin
            mod_ctl.start = 1'b1;
            mod_dividend  = BASE_W'(h_ff);
            mod_modulus   = MOD_W'(TABLE_SIZE);
            state_in      = S_FOLD;
         end
         S_FOLD: begin
            if (mod_sts.done) begin
               addr_in  = ADDR_W'(mod_rem);
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (!rd_data.used) begin
               if (mode_ff == MODE_LOOKUP) begin
                  res_status_in = ST_NOT_FOUND;
                  res_slot_in   = '0;
               end else begin
                  wr_en         = 1'b1;
                  res_status_in = ST_INSERTED;
                  res_slot_in   = addr_ff;
               end
               state_in = S_DONE;
            end else if (rd_data.key == key_ff) begin
               res_status_in = (mode_ff == MODE_LOOKUP) ? ST_FOUND : ST_DUPLICATE;
               res_slot_in   = addr_ff;
               state_in      = S_DONE;
            end else if (probe_ff == ADDR_W'(TABLE_SIZE - 1)) begin
               res_status_in = (mode_ff == MODE_LOOKUP) ? ST_NOT_FOUND : ST_FULL;
               res_slot_in   = '0;
               state_in      = S_DONE;
            end else begin
               probe_in = probe_ff + ADDR_W'(1);
               h_in     = h_next;
               addr_in  = ADDR_W'(h_next);
               state_in = FOLD ? S_FOLD_GO : S_READ;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      h_ff          <= h_in;
      addr_ff       <= addr_in;
      probe_ff      <= probe_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for fraction_key_open_address_hash_table_core.
// Uses fkhash_pkg and the fkhash_req_if / fkhash_rsp_if channels; a slot table
// tracker predicts each response and checks it under random handshake stalls.
`timescale 1ns / 100ps

module testbench;
   import fkhash_pkg::*;

   localparam int SLOTS           = TABLE_SIZE_DEF;
   localparam int MODULUS         = PRIME_MODULUS_DEF;
   localparam int SLOT_W          = SLOT_W_DEF;
   localparam int RANDOM_ITEMS    = 630;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 80;
   localparam int CYCLE_LIMIT     = 500000;

   typedef struct packed {
      status_type        status;
      logic [SLOT_W-1:0] slot;
   } outcome_type;

   class slot_table_tracker;
      bit               used[SLOTS];
      logic [KEY_W-1:0] keys[SLOTS];
      outcome_type      pending_outcomes[$];
      int unsigned      errors;

      function automatic logic [MAG_W-1:0] magnitude_of(logic [NUM_W-1:0] v);
         return v[NUM_W-1] ? ({1'b0, ~v} + MAG_W'(1)) : {1'b0, v};
      endfunction

      function automatic int unsigned probe_slot(int unsigned base, int unsigned i);
         int unsigned h;
         h = (base + PROBE_STEP * i) % MODULUS;
         if (h >= SLOTS) h = h % SLOTS;
         return h;
      endfunction

      function void note_request(logic mode, logic [NUM_W-1:0] num, logic [NUM_W-1:0] den);
         logic [KEY_W-1:0] key;
         int unsigned      base;
         int unsigned      h;
         bit               hit;
         outcome_type      o;
         key = {num, den};
         base = HASH_MUL_NUM * int'(magnitude_of(num)) + HASH_MUL_DEN * int'(magnitude_of(den));
         hit = 1'b0;
         o.slot = '0;
         for (int i = 0; i < SLOTS; i++) begin
            h = probe_slot(base, i);
            if (!used[h]) break;
            if (keys[h] == key) begin
               hit = 1'b1;
               o.slot = SLOT_W'(h);
               break;
            end
         end
         if (hit) begin
            o.status = (mode == MODE_LOOKUP) ? ST_FOUND : ST_DUPLICATE;
         end else if (mode == MODE_LOOKUP) begin
            o.status = ST_NOT_FOUND;
         end else begin
            o.status = ST_FULL;
            for (int i = 0; i < SLOTS; i++) begin
               h = probe_slot(base, i);
               if (!used[h]) begin
                  used[h] = 1'b1;
                  keys[h] = key;
                  o.status = ST_INSERTED;
                  o.slot = SLOT_W'(h);
                  break;
               end
            end
         end
         pending_outcomes = {pending_outcomes, o};
      endfunction

      function void check_response(status_type status, logic [SLOT_W-1:0] slot);
         outcome_type exp_o;
         if (pending_outcomes.size() == 0) begin
            $display("%0t: unexpected response status %0d slot %0d", $time, status, slot);
            errors++;
            return;
         end
         exp_o = pending_outcomes.pop_front();
         if (status !== exp_o.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_o.status, status);
            errors++;
         end
         if (slot !== exp_o.slot) begin
            $display("%0t: slot expected %0d actual %0d", $time, exp_o.slot, slot);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   fkhash_req_if req_ch ();
   fkhash_rsp_if rsp_ch ();

   fraction_key_open_address_hash_table_core dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   slot_table_tracker tracker;
   logic [KEY_W-1:0]  inserted_keys[$];
   int unsigned       send_idle_pct;
   int unsigned       recv_idle_pct;
   bit                hold_off_request;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) tracker.check_response(rsp_ch.status, rsp_ch.slot);
         if (req_ch.valid && req_ch.ready)
            tracker.note_request(req_ch.mode, req_ch.numerator, req_ch.denominator);
      end
   end

   initial begin : receiver
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("testbench: errors");
      $finish;
   end

   task automatic offer(input logic mode, input logic [NUM_W-1:0] num,
                        input logic [NUM_W-1:0] den);
      req_ch.valid       <= 1'b1;
      req_ch.mode        <= mode;
      req_ch.numerator   <= num;
      req_ch.denominator <= den;
      if (mode == MODE_INSERT) inserted_keys = {inserted_keys, {num, den}};
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   function automatic logic [NUM_W-1:0] draw_field();
      logic [NUM_W-1:0] v;
      case ($urandom_range(3))
         0: v = NUM_W'($urandom);
         1: begin
            v = NUM_W'($urandom_range(0, 20));
            if ($urandom_range(1)) v = -v;
         end
         2: begin
            case ($urandom_range(3))
               0: v = 16'h8000;
               1: v = 16'h7FFF;
               2: v = 16'hFFFF;
               default: v = 16'h0000;
            endcase
         end
         default: v = NUM_W'($urandom_range(0, 255)) ^ {1'($urandom_range(1)), 15'd0};
      endcase
      return v;
   endfunction

   task automatic run_random(input int unsigned count);
      logic [KEY_W-1:0] key;
      logic             mode;
      repeat (count) begin
         mode = $urandom_range(1) ? MODE_LOOKUP : MODE_INSERT;
         if (inserted_keys.size() != 0 && $urandom_range(1))
            key = inserted_keys[$urandom_range(inserted_keys.size() - 1)];
         else
            key = {draw_field(), draw_field()};
         offer(mode, key[KEY_W-1:NUM_W], key[NUM_W-1:0]);
      end
   endtask

   initial begin : stimulus
      tracker = new();
      hold_off_request = 1'b0;
      send_idle_pct = 19;
      recv_idle_pct = 75;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.mode = MODE_INSERT;
      req_ch.numerator = '0;
      req_ch.denominator = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // empty table, duplicates, magnitude extremes, shared-hash keys
      offer(MODE_LOOKUP, 16'h0000, 16'h0000);
      offer(MODE_INSERT, 16'h0000, 16'h0000);
      offer(MODE_INSERT, 16'h0000, 16'h0000);
      offer(MODE_LOOKUP, 16'h0000, 16'h0000);
      offer(MODE_INSERT, 16'h8000, 16'h8000);
      offer(MODE_INSERT, 16'h7FFF, 16'h7FFF);
      offer(MODE_INSERT, 16'h8000, 16'h7FFF);
      offer(MODE_INSERT, 16'h7FFF, 16'h8000);
      offer(MODE_LOOKUP, 16'h8000, 16'h8000);
      offer(MODE_INSERT, 16'h0005, 16'h0003);
      offer(MODE_INSERT, 16'hFFFB, 16'h0003);
      offer(MODE_INSERT, 16'h0005, 16'hFFFD);
      offer(MODE_INSERT, 16'hFFFB, 16'hFFFD);
      offer(MODE_LOOKUP, 16'hFFFB, 16'hFFFD);
      offer(MODE_LOOKUP, 16'hFFFB, 16'hFFFC);
      offer(MODE_INSERT, 16'hFFFF, 16'h0001);
      offer(MODE_LOOKUP, 16'h0001, 16'hFFFF);

      run_random(RANDOM_ITEMS);
      send_idle_pct = 75;
      recv_idle_pct = 19;
      run_random(RANDOM_ITEMS);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_off_request = 1'b1;
      run_random(RANDOM_ITEMS);
      req_ch.valid <= 1'b0;
      @(posedge clock);

      while (tracker.pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending_outcomes.size() == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end
endmodule

FILE: files.f
src/fkhash_pkg.sv
src/fkhash_ifs.sv
src/fkhash_mod.sv
src/fkhash_mem.sv
src/fraction_key_open_address_hash_table_core.sv
tb/testbench.sv
